@@ rtl/core/sls_pkg.sv @@
package sls_pkg;

	localparam int MAX_N      = 4;
	localparam int IDX_W      = 2;
	localparam int SIZE_W     = 3;
	localparam int VAL_W      = 32;
	localparam int RES_W      = 64;
	localparam int NPERM      = 24;
	localparam int PERM_W     = 5;
	localparam int LIMBS      = 4;
	localparam int LIMB_W     = 2;
	localparam int PROD_W     = LIMBS * VAL_W;
	localparam int SUM_W      = PROD_W + 8;
	localparam int NUM_W      = SUM_W + 32;
	localparam int DIV_CNT_W  = 8;
	localparam int TDATA_IN_W = 32;
	localparam int TDATA_OUT_W = 72;

	localparam logic KIND_COEF = 1'b0;
	localparam logic KIND_RHS  = 1'b1;
	localparam logic RK_DET    = 1'b0;
	localparam logic RK_X      = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SINGULAR = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_SEQ_ERR  = 2'd3;

	localparam logic REG_MATRIX_SIZE  = 1'b0;
	localparam logic REG_SOLVE_METHOD = 1'b1;

	// Permutations of four columns in lexicographic order; entry r sits in bits [2r+1:2r].
	localparam logic [2*MAX_N-1:0] PERM_TABLE [NPERM] = '{
		8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
		8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
		8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
		8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
	};
	localparam logic [NPERM-1:0] PERM_ODD = 24'h666666;

	typedef enum logic [3:0] {
		ST_LOAD, ST_PERM, ST_FETCH, ST_MUL, ST_ACC, ST_PASS_END,
		ST_DIV, ST_EMIT_DET, ST_EMIT_SING, ST_EMIT_X
	} state_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_SEQ_ERR, EM_DET, EM_SING, EM_X
	} emit_t;

	typedef struct packed {
		logic              wr_coef;
		logic              wr_rhs;
		logic [IDX_W-1:0]  wr_row;
		logic [IDX_W-1:0]  wr_col;
		logic              fetch;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              repl_en;
		logic [IDX_W-1:0]  repl_col;
		logic              prod_init;
		logic              prod_odd;
		logic              mul_step;
		logic [LIMB_W-1:0] limb;
		logic              sum_clr;
		logic              sum_acc;
		logic              det_save;
		logic              div_init;
		logic              div_step;
		emit_t             emit;
		logic [IDX_W-1:0]  emit_idx;
		logic              emit_last;
		logic [SIZE_W-1:0] n;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic sum_zero;
	} status_t;

	function automatic logic [IDX_W-1:0] perm_col(input logic [PERM_W-1:0] k,
		input logic [IDX_W-1:0] r);
		logic [2*MAX_N-1:0] entry;
		entry = PERM_TABLE[k];
		return entry[{r, 1'b0} +: IDX_W];
	endfunction

	// A permutation serves an order-n system when it leaves every row from n upward in place.
	function automatic logic perm_fits(input logic [PERM_W-1:0] k,
		input logic [SIZE_W-1:0] n);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < MAX_N; i++) begin
			if (i >= int'(n) && perm_col(k, IDX_W'(i)) != IDX_W'(i)) ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

@@ rtl/core/small_linear_system_solver.sv @@
// Channel   Dir  Contents
// s_*       in   tdata: value[31:0] Q16.16; tuser: kind (0 coefficient, 1 right-hand term)
// m_*       out  tdata: index[1:0], result_value[65:2], status[67:66]; tuser: result_kind; tlast
// cfg_*     in   index 0 matrix_size (3 bits), index 1 solve_method (no storage)
//
// Loading takes one word per cycle while the output register has room. A solve walks 24
// column permutations per pass, multiplying out each one that fits order n and skipping the
// rest; one pass finds the determinant, and each unknown adds a pass and a bit-serial divide.
// Exact products go through a single 32x32 multiplier one limb at a time.
// Reset clears control only; the matrix stores hold undefined data until loaded.
// A stalled output blocks the next result and the next load word.
module small_linear_system_solver (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sls_pkg::TDATA_IN_W-1:0]      s_tdata,   // value
	input  logic                                s_tuser,   // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sls_pkg::TDATA_OUT_W-1:0]     m_tdata,   // index, result_value, status, zero fill
	output logic                                m_tuser,   // result_kind
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [sls_pkg::SIZE_W-1:0]          cfg_data
);

	sls_pkg::cmd_t    cmd;
	sls_pkg::status_t status;

	sls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd)
	);

	sls_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_value  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/core/sls_ctrl.sv @@
module sls_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tuser,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sls_pkg::SIZE_W-1:0]    cfg_data,
	input  sls_pkg::status_t              status,
	output sls_pkg::cmd_t                 cmd
);

	sls_pkg::state_t state_q, state_d;
	logic [sls_pkg::SIZE_W-1:0]    msize_q;
	logic [sls_pkg::SIZE_W-1:0]    n_eff;
	logic [sls_pkg::IDX_W-1:0]     nm1;
	logic [sls_pkg::IDX_W-1:0]     ld_row_q, ld_col_q, row_q, col_q;
	logic                          ld_rhs_q, det_pass_q;
	logic [sls_pkg::PERM_W-1:0]    perm_q;
	logic [sls_pkg::LIMB_W-1:0]    limb_q;
	logic [sls_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic acc, mismatch, load_done, fits, perm_last, row_last, emit_fire;

	always_comb begin
		if (msize_q == '0) n_eff = sls_pkg::SIZE_W'(1);
		else if (msize_q > sls_pkg::SIZE_W'(sls_pkg::MAX_N)) n_eff = sls_pkg::SIZE_W'(sls_pkg::MAX_N);
		else n_eff = msize_q;
	end
	assign nm1       = sls_pkg::IDX_W'(n_eff - sls_pkg::SIZE_W'(1));
	assign acc       = s_tvalid && s_tready;
	assign mismatch  = s_tuser != ld_rhs_q;
	assign load_done = acc && !mismatch && ld_rhs_q && (ld_row_q == nm1);
	assign fits      = sls_pkg::perm_fits(perm_q, n_eff);
	assign perm_last = perm_q == sls_pkg::PERM_W'(sls_pkg::NPERM - 1);
	assign row_last  = row_q == nm1;
	assign emit_fire = status.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sls_pkg::ST_LOAD: if (load_done) state_d = sls_pkg::ST_PERM;
			sls_pkg::ST_PERM: begin
				if (fits) state_d = sls_pkg::ST_FETCH;
				else if (perm_last) state_d = sls_pkg::ST_PASS_END;
			end
			sls_pkg::ST_FETCH: state_d = sls_pkg::ST_MUL;
			sls_pkg::ST_MUL: begin
				if (limb_q == sls_pkg::LIMB_W'(sls_pkg::LIMBS - 1))
					state_d = row_last ? sls_pkg::ST_ACC : sls_pkg::ST_FETCH;
			end
			sls_pkg::ST_ACC: state_d = perm_last ? sls_pkg::ST_PASS_END : sls_pkg::ST_PERM;
			sls_pkg::ST_PASS_END: begin
				if (!det_pass_q) state_d = sls_pkg::ST_DIV;
				else if (status.sum_zero) state_d = sls_pkg::ST_EMIT_SING;
				else state_d = sls_pkg::ST_EMIT_DET;
			end
			sls_pkg::ST_DIV: begin
				if (div_cnt_q == sls_pkg::DIV_CNT_W'(sls_pkg::NUM_W - 1)) state_d = sls_pkg::ST_EMIT_X;
			end
			sls_pkg::ST_EMIT_DET: if (emit_fire) state_d = sls_pkg::ST_PERM;
			sls_pkg::ST_EMIT_SING: if (emit_fire) state_d = sls_pkg::ST_LOAD;
			sls_pkg::ST_EMIT_X: begin
				if (emit_fire) state_d = (col_q == nm1) ? sls_pkg::ST_LOAD : sls_pkg::ST_PERM;
			end
			default: state_d = sls_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.emit      = sls_pkg::EM_NONE;
		cmd.n         = n_eff;
		cmd.wr_row    = ld_row_q;
		cmd.wr_col    = ld_col_q;
		cmd.row       = row_q;
		cmd.col       = sls_pkg::perm_col(perm_q, row_q);
		cmd.repl_en   = !det_pass_q;
		cmd.repl_col  = col_q;
		cmd.prod_odd  = sls_pkg::PERM_ODD[perm_q];
		cmd.limb      = limb_q;
		cmd.emit_idx  = col_q;
		cmd.emit_last = col_q == nm1;
		s_tready      = 1'b0;
		case (state_q)
			sls_pkg::ST_LOAD: begin
				s_tready = status.out_free;
				if (acc) begin
					if (mismatch) cmd.emit = sls_pkg::EM_SEQ_ERR;
					else if (s_tuser == sls_pkg::KIND_COEF) cmd.wr_coef = 1'b1;
					else begin
						cmd.wr_rhs  = 1'b1;
						cmd.sum_clr = load_done;
					end
				end
			end
			sls_pkg::ST_PERM:  cmd.prod_init = fits;
			sls_pkg::ST_FETCH: cmd.fetch = 1'b1;
			sls_pkg::ST_MUL:   cmd.mul_step = 1'b1;
			sls_pkg::ST_ACC:   cmd.sum_acc = 1'b1;
			sls_pkg::ST_PASS_END: begin
				if (!det_pass_q) cmd.div_init = 1'b1;
				else if (!status.sum_zero) cmd.det_save = 1'b1;
			end
			sls_pkg::ST_DIV: cmd.div_step = 1'b1;
			sls_pkg::ST_EMIT_DET: begin
				if (emit_fire) begin
					cmd.emit    = sls_pkg::EM_DET;
					cmd.sum_clr = 1'b1;
				end
			end
			sls_pkg::ST_EMIT_SING: if (emit_fire) cmd.emit = sls_pkg::EM_SING;
			sls_pkg::ST_EMIT_X: begin
				if (emit_fire) begin
					cmd.emit    = sls_pkg::EM_X;
					cmd.sum_clr = 1'b1;
				end
			end
			default: cmd.emit = sls_pkg::EM_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sls_pkg::ST_LOAD;
			msize_q    <= sls_pkg::SIZE_W'(sls_pkg::MAX_N);
			ld_row_q   <= '0;
			ld_col_q   <= '0;
			ld_rhs_q   <= 1'b0;
			det_pass_q <= 1'b0;
			perm_q     <= '0;
			row_q      <= '0;
			col_q      <= '0;
			limb_q     <= '0;
			div_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == sls_pkg::REG_MATRIX_SIZE) begin
				msize_q  <= cfg_data;
				ld_row_q <= '0;
				ld_col_q <= '0;
				ld_rhs_q <= 1'b0;
			end else if (acc && !mismatch) begin
				if (!ld_rhs_q) begin
					if (ld_col_q == nm1) begin
						ld_col_q <= '0;
						if (ld_row_q == nm1) begin
							ld_row_q <= '0;
							ld_rhs_q <= 1'b1;
						end else ld_row_q <= ld_row_q + 1'b1;
					end else ld_col_q <= ld_col_q + 1'b1;
				end else if (ld_row_q == nm1) begin
					ld_row_q <= '0;
					ld_rhs_q <= 1'b0;
				end else ld_row_q <= ld_row_q + 1'b1;
			end
			if (load_done) det_pass_q <= 1'b1;
			else if (state_q == sls_pkg::ST_EMIT_DET && emit_fire) det_pass_q <= 1'b0;
			if (state_d == sls_pkg::ST_PERM && state_q != sls_pkg::ST_PERM &&
				state_q != sls_pkg::ST_ACC) perm_q <= '0;
			else if (((state_q == sls_pkg::ST_PERM && !fits) || state_q == sls_pkg::ST_ACC) &&
				!perm_last) perm_q <= perm_q + 1'b1;
			if (state_q == sls_pkg::ST_PERM) row_q <= '0;
			else if (state_q == sls_pkg::ST_MUL && limb_q == sls_pkg::LIMB_W'(sls_pkg::LIMBS - 1) &&
				!row_last) row_q <= row_q + 1'b1;
			if (state_q == sls_pkg::ST_FETCH) limb_q <= '0;
			else if (state_q == sls_pkg::ST_MUL) limb_q <= limb_q + 1'b1;
			if (state_q == sls_pkg::ST_EMIT_DET && emit_fire) col_q <= '0;
			else if (state_q == sls_pkg::ST_EMIT_X && emit_fire) col_q <= col_q + 1'b1;
			if (state_q == sls_pkg::ST_PASS_END) div_cnt_q <= '0;
			else if (state_q == sls_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	a_ready_only_loading: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == sls_pkg::ST_LOAD)
		else $error("input taken outside the load phase");
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != sls_pkg::EM_NONE |-> status.out_free)
		else $error("result issued while the output register is full");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sls_pkg::ST_DIV |=> state_q == sls_pkg::ST_DIV || state_q == sls_pkg::ST_EMIT_X)
		else $error("division left early");
	a_load_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sls_pkg::ST_LOAD |-> ld_row_q <= nm1)
		else $error("load row beyond matrix order");

endmodule

@@ rtl/core/sls_dp.sv @@
module sls_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [sls_pkg::VAL_W-1:0]         s_value,
	input  sls_pkg::cmd_t                     cmd,
	output sls_pkg::status_t                  status,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sls_pkg::TDATA_OUT_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);

	logic [sls_pkg::VAL_W-1:0]  coef_q [sls_pkg::MAX_N][sls_pkg::MAX_N];
	logic [sls_pkg::VAL_W-1:0]  rhs_q  [sls_pkg::MAX_N];
	logic [sls_pkg::VAL_W-1:0]  fac_q, carry_q, raw, raw_mag, limb_w;
	logic [sls_pkg::PROD_W-1:0] prod_q;
	logic                       prod_neg_q, det_neg_q, x_neg_q;
	logic signed [sls_pkg::SUM_W-1:0] sum_q, det_q;
	logic [sls_pkg::SUM_W-1:0]  sum_mag, den_q, prod_ext;
	logic [sls_pkg::NUM_W-1:0]  num_q, quo_q;
	logic [sls_pkg::SUM_W:0]    rem_q, trial;
	logic                       q_bit;
	logic [2*sls_pkg::VAL_W-1:0] mac;
	logic signed [sls_pkg::NUM_W-1:0] dwide;
	logic [sls_pkg::NUM_W-sls_pkg::RES_W:0] dhi;
	logic [sls_pkg::RES_W-1:0]  det_val, x_val;
	logic                       det_ovf, x_ovf;
	logic                       out_valid_q, out_kind_q, out_last_q;
	logic [sls_pkg::IDX_W-1:0]  out_idx_q;
	logic [sls_pkg::RES_W-1:0]  out_val_q;
	logic [1:0]                 out_stat_q;

	assign status.out_free = !out_valid_q || m_tready;
	assign status.sum_zero = sum_q == '0;

	assign raw = (cmd.repl_en && cmd.col == cmd.repl_col) ? rhs_q[cmd.row] : coef_q[cmd.row][cmd.col];
	assign raw_mag = raw[sls_pkg::VAL_W-1] ? (~raw + 1'b1) : raw;
	assign limb_w  = prod_q[{cmd.limb, 5'd0} +: sls_pkg::VAL_W];
	assign mac     = limb_w * fac_q + {{sls_pkg::VAL_W{1'b0}}, carry_q};
	assign prod_ext = {{(sls_pkg::SUM_W - sls_pkg::PROD_W){1'b0}}, prod_q};
	assign sum_mag = sum_q[sls_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	// One restoring step: shift in the next numerator bit, subtract the divisor when it fits.
	assign trial = {rem_q[sls_pkg::SUM_W-1:0], num_q[sls_pkg::NUM_W-1]};
	assign q_bit = trial >= {1'b0, den_q};

	// Raw products carry 16n fraction bits; Q32.32 needs a shift of 32 - 16n.
	always_comb begin
		case (cmd.n)
			3'd1:    dwide = $signed({det_q, 32'd0}) >>> 16;
			3'd2:    dwide = $signed({det_q, 32'd0}) >>> 32;
			3'd3:    dwide = $signed({det_q, 32'd0}) >>> 48;
			default: dwide = $signed({det_q, 32'd0}) >>> 64;
		endcase
		dhi     = dwide[sls_pkg::NUM_W-1:sls_pkg::RES_W-1];
		det_ovf = !(dhi == '0 || dhi == '1);
		if (!det_ovf) det_val = dwide[sls_pkg::RES_W-1:0];
		else if (dwide[sls_pkg::NUM_W-1]) det_val = {1'b1, {(sls_pkg::RES_W-1){1'b0}}};
		else det_val = {1'b0, {(sls_pkg::RES_W-1){1'b1}}};
	end

	always_comb begin
		if (x_neg_q) begin
			x_ovf = (|quo_q[sls_pkg::NUM_W-1:sls_pkg::RES_W]) ||
				(quo_q[sls_pkg::RES_W-1] && (|quo_q[sls_pkg::RES_W-2:0]));
			x_val = x_ovf ? {1'b1, {(sls_pkg::RES_W-1){1'b0}}} :
				(~quo_q[sls_pkg::RES_W-1:0] + 1'b1);
		end else begin
			x_ovf = |quo_q[sls_pkg::NUM_W-1:sls_pkg::RES_W-1];
			x_val = x_ovf ? {1'b0, {(sls_pkg::RES_W-1){1'b1}}} : quo_q[sls_pkg::RES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_coef) coef_q[cmd.wr_row][cmd.wr_col] <= s_value;
		if (cmd.wr_rhs) rhs_q[cmd.wr_row] <= s_value;
		if (cmd.prod_init) begin
			prod_q     <= sls_pkg::PROD_W'(1);
			prod_neg_q <= cmd.prod_odd;
		end else if (cmd.fetch) begin
			fac_q      <= raw_mag;
			carry_q    <= '0;
			prod_neg_q <= prod_neg_q ^ raw[sls_pkg::VAL_W-1];
		end else if (cmd.mul_step) begin
			prod_q[{cmd.limb, 5'd0} +: sls_pkg::VAL_W] <= mac[sls_pkg::VAL_W-1:0];
			carry_q <= mac[2*sls_pkg::VAL_W-1:sls_pkg::VAL_W];
		end
		if (cmd.sum_clr) sum_q <= '0;
		else if (cmd.sum_acc) sum_q <= prod_neg_q ? sum_q - $signed(prod_ext) : sum_q + $signed(prod_ext);
		if (cmd.det_save) begin
			det_q     <= sum_q;
			den_q     <= sum_mag;
			det_neg_q <= sum_q[sls_pkg::SUM_W-1];
		end
		if (cmd.div_init) begin
			num_q   <= {sum_mag, 32'd0};
			rem_q   <= '0;
			quo_q   <= '0;
			x_neg_q <= sum_q[sls_pkg::SUM_W-1] ^ det_neg_q;
		end else if (cmd.div_step) begin
			num_q <= {num_q[sls_pkg::NUM_W-2:0], 1'b0};
			rem_q <= q_bit ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[sls_pkg::NUM_W-2:0], q_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit != sls_pkg::EM_NONE) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			sls_pkg::EM_SEQ_ERR: begin
				out_kind_q <= sls_pkg::RK_DET;
				out_idx_q  <= '0;
				out_val_q  <= '0;
				out_stat_q <= sls_pkg::STAT_SEQ_ERR;
				out_last_q <= 1'b0;
			end
			sls_pkg::EM_SING: begin
				out_kind_q <= sls_pkg::RK_DET;
				out_idx_q  <= '0;
				out_val_q  <= '0;
				out_stat_q <= sls_pkg::STAT_SINGULAR;
				out_last_q <= 1'b1;
			end
			sls_pkg::EM_DET: begin
				out_kind_q <= sls_pkg::RK_DET;
				out_idx_q  <= '0;
				out_val_q  <= det_val;
				out_stat_q <= det_ovf ? sls_pkg::STAT_OVERFLOW : sls_pkg::STAT_OK;
				out_last_q <= 1'b0;
			end
			sls_pkg::EM_X: begin
				out_kind_q <= sls_pkg::RK_X;
				out_idx_q  <= cmd.emit_idx;
				out_val_q  <= x_val;
				out_stat_q <= x_ovf ? sls_pkg::STAT_OVERFLOW : sls_pkg::STAT_OK;
				out_last_q <= cmd.emit_last;
			end
			default: out_kind_q <= out_kind_q;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'd0, out_stat_q, out_val_q, out_idx_q};

endmodule
